// File: rtl/pwcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwcr_pkg
// types, register indexes and colour helpers for the waveform column renderer
// ----------------------------------------------------------------------------
package pwcr_pkg;

  // largest half height of a column in rows
  localparam logic [5:0] MaxHalfHeight = 6'd32;
  // largest decimation factor per channel
  localparam logic [6:0] MaxPickSkip   = 7'd64;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_HALF_HEIGHT    = 3'd0,
    REG_SAMPLE_MODE    = 3'd1,
    REG_CHANNEL_COUNT  = 3'd2,
    REG_PICK_SKIP      = 3'd3,
    REG_DRAW_COLOR     = 3'd4,
    REG_BORDER_COLOR   = 3'd5,
    REG_CENTER_COLOR   = 3'd6,
    REG_BACKDROP_COLOR = 3'd7
  } cfg_reg_t;

  // which scaling a kept sample goes through
  typedef enum logic [1:0] {
    SCALE_U8  = 2'd0,
    SCALE_POS = 2'd1,
    SCALE_NEG = 2'd2
  } scale_kind_t;

  // rgb888 to rgb565 by keeping the top bits of each channel
  function automatic logic [15:0] to565(input logic [23:0] c);
    to565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/pcm_waveform_column_renderer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_waveform_column_renderer_unit
// decimates a pcm stream and draws each kept sample as a column of rgb565 rows
// ----------------------------------------------------------------------------
// pipeline: a kept sample passes stage 1, stage 2, the row emitter and the
//   output register; rows then follow one per cycle while out_stall is low
// throughput: a sample is taken every cycle unless in_stall is high; a kept
//   sample holds the row emitter until its last row has been loaded out
// reset: synchronous, active high; configuration registers return to their
//   defaults, decimation state and all stage valids clear
module pcm_waveform_column_renderer_unit
  import pwcr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // sample channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] sample,
  input  wire logic               packet_start,
  input  wire logic        [15:0] packet_samples,
  // pixel channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [5:0]  row,
  output logic             [15:0] pixel_color,
  output logic                    last_row,
  // configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [23:0] cfg_data
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [5:0]  half_height;
  logic        sample_mode;
  logic [1:0]  channel_count;
  logic [6:0]  pick_skip;
  logic [23:0] draw_color;
  logic [23:0] border_color;
  logic [23:0] center_color;
  logic [23:0] backdrop_color;

  // writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_height    <= 6'd32;
      sample_mode    <= 1'b1;
      channel_count  <= 2'd2;
      pick_skip      <= 7'd4;
      draw_color     <= 24'd65535;
      border_color   <= 24'd13882323;
      center_color   <= 24'd14745599;
      backdrop_color <= 24'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HALF_HEIGHT:    half_height    <= cfg_data[5:0];
        REG_SAMPLE_MODE:    sample_mode    <= cfg_data[0];
        REG_CHANNEL_COUNT:  channel_count  <= cfg_data[1:0];
        REG_PICK_SKIP:      pick_skip      <= cfg_data[6:0];
        REG_DRAW_COLOR:     draw_color     <= cfg_data;
        REG_BORDER_COLOR:   border_color   <= cfg_data;
        REG_CENTER_COLOR:   center_color   <= cfg_data;
        REG_BACKDROP_COLOR: backdrop_color <= cfg_data;
      endcase
    end
  end

  // out-of-range settings fold back into range
  logic [5:0] h_eff;
  logic [6:0] skip_eff;
  logic       two_ch;
  logic [8:0] step;

  always_comb begin
    priority if (half_height == 6'd0)        h_eff = 6'd1;
    else if (half_height > MaxHalfHeight)    h_eff = MaxHalfHeight;
    else                                     h_eff = half_height;

    priority if (pick_skip == 7'd0)          skip_eff = 7'd1;
    else if (pick_skip > MaxPickSkip)        skip_eff = MaxPickSkip;
    else                                     skip_eff = pick_skip;

    // channel count 0 acts as one channel, 3 as two
    two_ch = channel_count[1];
    // step = skip * channels, doubled for byte samples; never above 256
    step = {2'b00, skip_eff} << ({1'b0, two_ch} + {1'b0, ~sample_mode});
  end

  // rgb565 forms of the palette
  logic [15:0] draw565, border565, center565, back565;
  assign draw565   = to565(draw_color);
  assign border565 = to565(border_color);
  assign center565 = to565(center_color);
  assign back565   = to565(backdrop_color);

  // --------------------------------------------------------------------------
  // pipeline flow control
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, em_valid;
  logic [5:0] row_cnt;
  logic [5:0] last_cnt;
  logic out_load, em_done, em_free, s2_go, s2_free, s1_go, s1_free;
  logic in_take;

  assign last_cnt = 6'({h_eff, 1'b0} - 7'd1);
  assign out_load = em_valid && (!out_valid || !out_stall);
  assign em_done  = out_load && (row_cnt == last_cnt);
  assign em_free  = !em_valid || em_done;
  assign s2_go    = s2_valid && em_free;
  assign s2_free  = !s2_valid || s2_go;
  assign s1_go    = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s1_go;
  assign in_stall = !s1_free;
  assign in_take  = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // decimation, evaluated on every accepted transaction
  // --------------------------------------------------------------------------
  logic [15:0] sample_index, sample_index_next;
  logic [8:0]  pick_countdown, pick_countdown_next;
  logic [15:0] idx_eff;
  logic [8:0]  cd_eff;
  logic        keep;

  always_comb begin
    // a packet start restarts the group count at this sample
    idx_eff = packet_start ? 16'd0 : sample_index;
    cd_eff  = packet_start ? 9'd0  : pick_countdown;
    // candidate only drawn when its whole group lies inside the packet
    keep = (cd_eff == 9'd0) &&
           (({1'b0, idx_eff} + {8'd0, step}) <= {1'b0, packet_samples});
    pick_countdown_next = (cd_eff == 9'd0) ? (step - 9'd1) : (cd_eff - 9'd1);
    // index saturates at the top
    sample_index_next = (idx_eff == 16'hFFFF) ? idx_eff : (idx_eff + 16'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index   <= 16'd0;
      pick_countdown <= 9'd0;
    end else if (in_take) begin
      sample_index   <= sample_index_next;
      pick_countdown <= pick_countdown_next;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: multiplier operands of the kept sample
  // --------------------------------------------------------------------------
  logic [15:0]  s1_a;
  logic [5:0]   s1_b;
  scale_kind_t  s1_kind;
  logic [15:0]  op_a;
  logic [5:0]   op_b;
  scale_kind_t  op_kind;
  logic [15:0]  raw;

  always_comb begin
    raw = sample;
    priority if (!sample_mode) begin
      // byte sample scaled by 2H-1 over 255
      op_a    = {8'd0, raw[7:0]};
      op_b    = last_cnt;
      op_kind = SCALE_U8;
    end else if (!raw[15]) begin
      // positive word scaled by H-1 over 32767
      op_a    = {1'b0, raw[14:0]};
      op_b    = h_eff - 6'd1;
      op_kind = SCALE_POS;
    end else begin
      // magnitude of a negative word scaled by H over 32768
      op_a    = ~raw + 16'd1;
      op_b    = h_eff;
      op_kind = SCALE_NEG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_take && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_a    <= op_a;
      s1_b    <= op_b;
      s1_kind <= op_kind;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: registered product
  // --------------------------------------------------------------------------
  logic [21:0]  s2_prod;
  scale_kind_t  s2_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_prod <= s1_a * {10'd0, s1_b};
      s2_kind <= s1_kind;
    end
  end

  // division by constants: reciprocal-style correction, exact for these ranges
  logic [15:0] t8;
  logic [20:0] tpos;
  logic [5:0]  bar_mag;
  logic        bar_neg;
  logic        bar_u8;

  always_comb begin
    t8   = 16'(s2_prod[14:0]) + 16'(s2_prod[14:8]) + 16'd1;
    tpos = 21'(s2_prod[19:0]) + 21'(s2_prod[19:15]) + 21'd1;
    bar_neg = 1'b0;
    bar_u8  = 1'b0;
    unique case (s2_kind)
      SCALE_U8: begin
        bar_mag = t8[13:8];
        bar_u8  = 1'b1;
      end
      SCALE_POS: bar_mag = tpos[20:15];
      SCALE_NEG: begin
        bar_mag = s2_prod[20:15];
        bar_neg = 1'b1;
      end
      default:   bar_mag = 6'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // row emitter: while out_stall is low, one row of the column per cycle
  // --------------------------------------------------------------------------
  logic [5:0] em_mag;
  logic       em_neg;
  logic       em_u8;

  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
      row_cnt  <= 6'd0;
    end else if (s2_go) begin
      em_valid <= 1'b1;
      row_cnt  <= 6'd0;
    end else if (em_done) begin
      em_valid <= 1'b0;
    end else if (out_load) begin
      row_cnt  <= row_cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      em_mag <= bar_mag;
      em_neg <= bar_neg;
      em_u8  <= bar_u8;
    end
  end

  // colour of the current row; sums kept in 8 bits so nothing goes negative
  logic [7:0]  r8, h8, m8;
  logic [15:0] row_color;

  always_comb begin
    r8 = {2'b00, row_cnt};
    h8 = {2'b00, h_eff};
    m8 = {2'b00, em_mag};
    if (em_u8) begin
      // bottom row is the centre line, bar grows upward from it
      priority if (row_cnt == last_cnt)          row_color = center565;
      else if ((r8 + 8'd1 + m8) >= (h8 << 1))    row_color = draw565;
      else if (row_cnt == 6'd0)                  row_color = border565;
      else                                       row_color = back565;
    end else begin
      // centre line at row H-1, positive bar above it, negative bar below
      priority if (!em_neg && (em_mag != 6'd0) &&
                   ((r8 + 8'd1 + m8) >= h8) && ((r8 + 8'd2) <= h8))
        row_color = draw565;
      else if (em_neg && (r8 >= h8) && ((r8 + 8'd1) <= (h8 + m8)))
        row_color = draw565;
      else if ((r8 + 8'd1) == h8)
        row_color = center565;
      else if ((row_cnt == 6'd0) || (row_cnt == last_cnt))
        row_color = border565;
      else
        row_color = back565;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row         <= row_cnt;
      pixel_color <= row_color;
      last_row    <= (row_cnt == last_cnt);
    end
  end

endmodule
`default_nettype wire
